### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/ascd_pkg.sv
// ----------------------------------------------------------------------------
// ascd_pkg
// Widths, register indexes and fixed constants of the silence cut detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ascd_pkg;

  // payload widths
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 24;
  localparam int TIME_W   = 32;
  localparam int CUT_W    = 6;

  // state widths
  localparam int SUM_W = 28;
  localparam int RUN_W = 24;

  // configuration port
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int RATE_W    = 18;
  localparam int CHAN_W    = 4;
  localparam int BPS_W     = 6;
  localparam int MINRUN_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SAMP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENT    = 2'd3;

  localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE   = 18'd44100;
  localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = 4'd2;
  localparam logic [BPS_W-1:0]    RST_BITS_PER_SAMP = 6'd16;
  localparam logic [MINRUN_W-1:0] RST_MIN_SILENT    = 8'd4;

  // rate * channels * bits, and that product divided by one thousand
  localparam int RATEPROD_W = RATE_W + CHAN_W + BPS_W;
  localparam int DIV_W      = 19;

  // divide by 1000 as a shift by 3, then a reciprocal multiply for 125:
  // floor(y * RECIP_125 / 2^32) equals floor(y / 125) for every y below 2^25
  localparam int MS_SHIFT    = 3;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;

  localparam logic [SUM_W-1:0] SILENT_LIMIT = 28'd32767;

endpackage

`default_nettype wire

### sv/audio_silence_cut_detector.sv
// A sample that does not close a frame, or closes one with no cut, is taken in S_IDLE;
// a frame end that emits a cut holds the input through S_DIFF, S_MUL_A, S_MUL_B, S_SCALE,
// the bit-per-cycle time divider (S_DIV_TIME) and S_LOAD, which waits on a stalled output.
// Throughput: one sample per cycle between cuts; input stalls while a cut is computed.
// Reset (rst, synchronous): clears frame sum, counts, silent run and cut count, and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// audio_silence_cut_detector
// Sums sample magnitudes per frame, tracks runs of silent frames and reports
// cut times in milliseconds through an iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module audio_silence_cut_detector #(
  parameter int MAX_CUTS          = 50,
  parameter int MAX_FRAME_SAMPLES = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_write,
  input  wire logic [ascd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ascd_pkg::CFG_W-1:0]      cfg_data,
  // sample requests
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [ascd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [ascd_pkg::FRAME_W-1:0]    frame_id,
  input  wire logic                            last_of_frame,
  // cut requests
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ascd_pkg::TIME_W-1:0]          cut_time_ms,
  output logic [ascd_pkg::CUT_W-1:0]           cut_number,
  output logic                                 list_full
);

  import ascd_pkg::*;

  localparam int CNT_W     = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int NUM_W     = FRAME_W + CNT_W + 4;
  localparam int ITER_W    = $clog2(NUM_W);
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int PROD_HI_W = RATEPROD_W - MS_SHIFT;
  localparam int SCALE_W   = PROD_HI_W + RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_A,
    S_MUL_B,
    S_SCALE,
    S_DIV_TIME,
    S_LOAD
  } state_t;

  state_t state;

  // configuration
  logic [RATE_W-1:0]   sample_rate;
  logic [CHAN_W-1:0]   channel_count;
  logic [BPS_W-1:0]    bits_per_sample;
  logic [MINRUN_W-1:0] min_silent_frames;

  // frame state
  logic [SUM_W-1:0] magnitude_sum;
  logic [CNT_W-1:0] samples_in_frame;
  logic [RUN_W-1:0] silent_run;
  logic [CUT_W-1:0] cuts_made;

  // pending cut
  logic [FRAME_W-1:0]  frame_q;
  logic [RUN_W-1:0]    run_q;
  logic [CNT_W-1:0]    nsamp_q;
  logic [CUT_W-1:0]    number_q;
  logic                full_q;
  logic [FRAME_W-1:0]  diff_q;
  logic [NUM_W-1:0]    num_q;
  logic [RATE_W+CHAN_W-1:0] prod_a;
  logic [RATEPROD_W-1:0] rate_prod;
  logic [TIME_W-1:0]   time_q;

  // time divider
  logic [DIV_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DIV_W-1:0]  dv;
  logic [ITER_W-1:0] iter;

  logic               in_take;
  logic               out_take;
  logic               out_free;
  logic               load_out;
  logic [MAG_W-1:0]   mag;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   count_next;
  logic               is_silent;
  logic               cut_hit;
  logic [SCALE_W-1:0] scaled;
  logic [DIV_W:0]     shifted;
  logic               ge;
  logic [DIV_W:0]     sub;
  logic [DIV_W-1:0]   rem_next;
  logic [NUM_W-1:0]   quo_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == S_LOAD) && out_free;

  // sample magnitude and saturating frame sum
  always_comb begin
    mag      = sample[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, sample}
                                  : {1'b0, sample};
    sum_ext  = {1'b0, magnitude_sum} + (SUM_W+1)'(mag);
    sum_next = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    count_next = (samples_in_frame < CNT_W'(MAX_FRAME_SAMPLES)) ?
                 samples_in_frame + CNT_W'(1) : samples_in_frame;
    is_silent = (sum_next < SILENT_LIMIT);
    cut_hit   = !is_silent && (silent_run >= RUN_W'(min_silent_frames));
  end

  // bits per millisecond: rate product over one thousand
  always_comb begin
    scaled = SCALE_W'(rate_prod[RATEPROD_W-1:MS_SHIFT]) * SCALE_W'(RECIP_125);
  end

  // one restoring divide step
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    ge       = (shifted >= {1'b0, dv});
    sub      = shifted - {1'b0, dv};
    rem_next = ge ? sub[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_next = {quo[NUM_W-2:0], ge};
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      sample_rate       <= RST_SAMPLE_RATE;
      channel_count     <= RST_CHANNEL_COUNT;
      bits_per_sample   <= RST_BITS_PER_SAMP;
      min_silent_frames <= RST_MIN_SILENT;
      magnitude_sum     <= '0;
      samples_in_frame  <= '0;
      silent_run        <= '0;
      cuts_made         <= '0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE:   sample_rate       <= cfg_data[RATE_W-1:0];
          REG_CHANNEL_COUNT: channel_count     <= cfg_data[CHAN_W-1:0];
          REG_BITS_PER_SAMP: bits_per_sample   <= cfg_data[BPS_W-1:0];
          REG_MIN_SILENT:    min_silent_frames <= cfg_data[MINRUN_W-1:0];
          default: ;
        endcase
      end

      // output register: load a finished cut, else drop a taken one
      if (load_out) begin
        cut_time_ms <= time_q;
        cut_number  <= number_q;
        list_full   <= full_q;
        out_valid   <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (!last_of_frame) begin
              magnitude_sum    <= sum_next;
              samples_in_frame <= count_next;
            end else begin
              magnitude_sum    <= '0;
              samples_in_frame <= '0;
              if (is_silent) begin
                if (silent_run != {RUN_W{1'b1}}) begin
                  silent_run <= silent_run + RUN_W'(1);
                end
              end else begin
                silent_run <= '0;
                if (cut_hit) begin
                  frame_q  <= frame_id;
                  run_q    <= silent_run;
                  nsamp_q  <= count_next;
                  number_q <= cuts_made;
                  full_q   <= (cuts_made >= CUT_W'(MAX_CUTS));
                  if (cuts_made < CUT_W'(MAX_CUTS)) begin
                    cuts_made <= cuts_made + CUT_W'(1);
                  end
                  state <= S_DIFF;
                end
              end
            end
          end
        end

        // frame distance, clamped at zero
        S_DIFF: begin
          diff_q <= (frame_q >= run_q) ? frame_q - run_q : '0;
          state  <= S_MUL_A;
        end

        // bit count of the span and rate times channels
        S_MUL_A: begin
          num_q  <= NUM_W'(diff_q) * NUM_W'({nsamp_q, 4'b0000});
          prod_a <= (RATE_W+CHAN_W)'(sample_rate) * (RATE_W+CHAN_W)'(channel_count);
          state  <= S_MUL_B;
        end

        // times bits per sample
        S_MUL_B: begin
          rate_prod <= RATEPROD_W'(prod_a) * RATEPROD_W'(bits_per_sample);
          state     <= S_SCALE;
        end

        // bits per millisecond into the divider; a zero divisor makes every
        // step subtract, so the quotient saturates on its own
        S_SCALE: begin
          quo   <= num_q;
          rem   <= '0;
          dv    <= scaled[RECIP_SHIFT +: DIV_W];
          iter  <= ITER_W'(NUM_W - 1);
          state <= S_DIV_TIME;
        end

        // milliseconds, saturated
        S_DIV_TIME: begin
          rem  <= rem_next;
          quo  <= quo_next;
          iter <= iter - ITER_W'(1);
          if (iter == '0) begin
            time_q <= (|quo_next[NUM_W-1:TIME_W]) ? {TIME_W{1'b1}}
                                                  : quo_next[TIME_W-1:0];
            state  <= S_LOAD;
          end
        end

        // hand the cut to the output register once it is free
        S_LOAD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_NEVER(a_cuts_bound, clk, rst, cuts_made > CUT_W'(MAX_CUTS),
    "cut count passed its limit")
  `ASSERT_NEVER(a_frame_count, clk, rst,
    samples_in_frame > CNT_W'(MAX_FRAME_SAMPLES), "frame sample count passed its limit")
  `ASSERT_NEVER(a_counted_cut, clk, rst, out_valid && !list_full && (cut_number >= cuts_made),
    "counted cut not reflected in cut count")

endmodule

`default_nettype wire

### tb/audio_silence_cut_detector_tb.sv
// ----------------------------------------------------------------------------
// audio_silence_cut_detector_tb
// Feeds framed audio samples through valid/stall handshakes and checks every
// reported cut against a cycle-free predictor of frame energy, silent runs and
// cut times. The run steps through several register settings, including the
// field extremes, a zero divisor, a zero minimum run and a full cut list.
// ----------------------------------------------------------------------------
module audio_silence_cut_detector_tb;
  import ascd_pkg::*;

  localparam int MAX_CUTS          = 50;
  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam int QUIET_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum {FR_SILENT, FR_LOUD, FR_NOISE, FR_FULL} frame_kind_t;

  typedef struct {
    logic [SAMPLE_W-1:0] pcm;
    logic [FRAME_W-1:0]  id;
    logic                last;
  } sample_req_t;

  typedef struct {
    logic [TIME_W-1:0] ms;
    logic [CUT_W-1:0]  ordinal;
    logic              full;
  } cut_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [FRAME_W-1:0] frame_id = '0;
  logic last_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] cut_time_ms;
  logic [CUT_W-1:0] cut_number;
  logic list_full;

  audio_silence_cut_detector dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .frame_id(frame_id),
    .last_of_frame(last_of_frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cut_time_ms(cut_time_ms),
    .cut_number(cut_number),
    .list_full(list_full)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [RATE_W-1:0]   rate       = RST_SAMPLE_RATE;
  logic [CHAN_W-1:0]   chans      = RST_CHANNEL_COUNT;
  logic [BPS_W-1:0]    bps        = RST_BITS_PER_SAMP;
  logic [MINRUN_W-1:0] min_silent = RST_MIN_SILENT;

  // detector state
  logic [SUM_W-1:0] mag_sum = '0;
  logic [12:0]      frame_len = '0;
  logic [RUN_W-1:0] silent_run = '0;
  logic [CUT_W-1:0] cuts_made = '0;

  sample_req_t sample_q[$];
  cut_t        cut_q[$];
  int          pushed_count = 0;
  int          taken_count = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        in_taken = 1'b0;
  logic [FRAME_W-1:0] next_id = '0;
  int unsigned cycles = 0;

  // cut position in ms for a loud frame closing with the given id
  function automatic logic [TIME_W-1:0] cut_ms(input logic [FRAME_W-1:0] id,
                                               input logic [12:0] n);
    logic [63:0] span, bits, divisor, q;
    span = (id >= silent_run) ? 64'(id - silent_run) : 64'd0;
    bits = span * n * 64'd16;
    divisor = (64'(rate) * chans * bps) / 64'd1000;
    if (divisor == 0) return '1;
    q = bits / divisor;
    return (q > 64'hFFFF_FFFF) ? '1 : q[TIME_W-1:0];
  endfunction

  // accumulate one sample, close the frame on its last sample
  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] pcm,
                                        input logic [FRAME_W-1:0] id,
                                        input logic last);
    logic [16:0] mag;
    logic [SUM_W:0] total;
    logic [12:0] n;
    logic [SUM_W-1:0] frame_sum;
    cut_t c;
    mag = pcm[SAMPLE_W-1] ? 17'h10000 - {1'b0, pcm} : {1'b0, pcm};
    total = mag_sum + mag;
    mag_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
    if (frame_len < MAX_FRAME_SAMPLES) frame_len++;
    if (!last) return;
    n = frame_len;
    frame_sum = mag_sum;
    mag_sum = '0;
    frame_len = '0;
    if (frame_sum < SILENT_LIMIT) begin
      if (silent_run != RUN_MAX) silent_run++;
      return;
    end
    if (silent_run >= min_silent) begin
      c.ms = cut_ms(id, n);
      c.ordinal = cuts_made;
      c.full = (cuts_made >= MAX_CUTS);
      if (!c.full) cuts_made++;
      cut_q.push_back(c);
    end
    silent_run = '0;
  endfunction

  function automatic void push_sample(input logic [SAMPLE_W-1:0] pcm,
                                      input logic [FRAME_W-1:0] id,
                                      input logic last);
    sample_req_t req;
    req.pcm = pcm;
    req.id = id;
    req.last = last;
    sample_q.push_back(req);
    pushed_count++;
  endfunction

  // one frame of n samples; only the last sample's id counts
  function automatic void push_frame(input int n, input frame_kind_t kind);
    logic [SAMPLE_W-1:0] pcm;
    logic [FRAME_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      case (kind)
        FR_SILENT: pcm = 16'($urandom_range(16000)) - 16'd8000;
        FR_NOISE:  pcm = 16'($urandom);
        FR_FULL:   pcm = 16'h8000;
        default: begin
          if (i < n - 1) begin
            pcm = 16'($urandom);
          end else begin
            case ($urandom_range(2))
              0: pcm = 16'sd32767;
              1: pcm = -16'sd32767;
              default: pcm = 16'h8000;
            endcase
          end
        end
      endcase
      id = ($urandom_range(7) == 0 && i < n - 1) ? 24'($urandom) : next_id;
      push_sample(pcm, id, i == n - 1);
    end
    next_id = ($urandom_range(9) == 0) ? 24'($urandom) : next_id + 1'b1;
  endfunction

  // silent frames followed by a loud one
  function automatic void push_segment(input int k, input int loud_len);
    for (int j = 0; j < k; j++)
      push_frame((min_silent > 16) ? 1 : 1 + $urandom_range(3), FR_SILENT);
    push_frame(loud_len, FR_LOUD);
  endfunction

  // mostly well-formed segments, the rest short runs and noise frames
  function automatic void random_phase(input int budget, input int want_cuts);
    int first, cuts, k;
    first = pushed_count;
    cuts = 0;
    while (pushed_count - first < budget || cuts < want_cuts) begin
      if ($urandom_range(99) < 80) begin
        if (min_silent == 0 || $urandom_range(6) != 0) begin
          k = int'(min_silent) + $urandom_range(2);
          cuts++;
        end else begin
          k = $urandom_range(int'(min_silent) - 1);
        end
        push_segment(k, 1 + $urandom_range(5));
      end else begin
        push_frame(1 + $urandom_range(4), FR_NOISE);
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SAMPLE_RATE:   rate = value[RATE_W-1:0];
      REG_CHANNEL_COUNT: chans = value[CHAN_W-1:0];
      REG_BITS_PER_SAMP: bps = value[BPS_W-1:0];
      REG_MIN_SILENT:    min_silent = value[MINRUN_W-1:0];
    endcase
  endtask

  // wait for every request to be taken and every cut to arrive
  task automatic settle();
    while (taken_count != pushed_count || cut_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                          input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] m);
    write_reg(REG_SAMPLE_RATE, r);
    write_reg(REG_CHANNEL_COUNT, c);
    write_reg(REG_BITS_PER_SAMP, b);
    write_reg(REG_MIN_SILENT, m);
  endtask

  // sample request driver
  always @(negedge clk) begin : drive
    sample_req_t req;
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = sample_q.pop_front();
        sample <= req.pcm;
        frame_id <= req.id;
        last_of_frame <= req.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on accepted samples, check accepted cuts
  always @(posedge clk) begin : watch
    cut_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        taken_count++;
        absorb_sample(sample, frame_id, last_of_frame);
      end
      if (out_valid && !out_stall) begin
        if (cut_q.size() == 0) begin
          errors++;
          $display("%0t: cut expected none actual ms %0d number %0d full %0d",
                   $time, cut_time_ms, cut_number, list_full);
        end else begin
          want = cut_q.pop_front();
          if (cut_time_ms !== want.ms) begin
            errors++;
            $display("%0t: cut_time_ms expected %0d actual %0d", $time, want.ms, cut_time_ms);
          end
          if (cut_number !== want.ordinal) begin
            errors++;
            $display("%0t: cut_number expected %0d actual %0d",
                     $time, want.ordinal, cut_number);
          end
          if (list_full !== want.full) begin
            errors++;
            $display("%0t: list_full expected %0d actual %0d", $time, want.full, list_full);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset settings, sender idles lightly, receiver stalls half the time
    send_idle_pct = 21;
    recv_stall_pct = 50;
    // silent frames at the limit edge, then a loud frame whose last id is below the run
    push_sample(16'sd0, 24'd5, 1'b1);
    push_sample(16'sd32766, 24'd6, 1'b1);
    push_sample(-16'sd1, 24'd7, 1'b0);
    push_sample(16'sd1, 24'd7, 1'b1);
    push_sample(16'sd0, 24'hFFFFFF, 1'b1);
    push_sample(16'h8000, 24'd9, 1'b0);
    push_sample(16'sd32767, 24'd1, 1'b1);
    // quiet pair summing to one below the limit, then a cut at the top frame id
    push_sample(16'sd16383, 24'd20, 1'b0);
    push_sample(16'sd16383, 24'd20, 1'b1);
    push_sample(-16'sd8, 24'd21, 1'b1);
    push_sample(16'sd0, 24'd22, 1'b1);
    push_sample(16'sd100, 24'd23, 1'b1);
    push_sample(16'sd32767, 24'hFFFFFF, 1'b1);
    // loud frame without a run, then a short run cleared by a loud frame
    push_sample(16'h8000, 24'd3, 1'b1);
    push_sample(16'sd0, 24'd4, 1'b1);
    push_sample(16'sd0, 24'd5, 1'b1);
    push_sample(16'sd16384, 24'd6, 1'b0);
    push_sample(16'sd16383, 24'd6, 1'b1);
    // loud frame at exactly the limit after a full run
    repeat (4) push_sample(-16'sd2, 24'd30, 1'b1);
    push_sample(-16'sd32767, 24'd0, 1'b1);
    random_phase(40, 4);

    // lowest rate, channels and bits, minimum run of one
    settle();
    set_regs(18'd8000, 18'd1, 18'd8, 18'd1);
    random_phase(30, 4);

    // highest legal settings, longest minimum run never reached; sender idles more now
    settle();
    send_idle_pct = 50;
    recv_stall_pct = 21;
    set_regs(18'd192000, 18'd8, 18'd32, 18'd255);
    repeat (3) push_segment(4 + $urandom_range(4), 1 + $urandom_range(3));

    // all register bits set, zero minimum run: every loud frame cuts, list fills up
    settle();
    set_regs(18'h3FFFF, 18'd15, 18'd63, 18'd0);
    random_phase(40, 10);
    repeat (36) push_frame(1, FR_LOUD);

    // divisor of one: long loud frame at a high id saturates the time
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_regs(18'd1000, 18'd1, 18'd1, 18'd2);
    next_id = 24'hFFFFF0;
    push_segment(2, 24);
    random_phase(20, 2);

    // channel count masked to zero gives a zero divisor; upper bits dropped
    settle();
    set_regs(18'd5000, 18'h3FFF0, 18'd16, 18'h20003);
    random_phase(20, 3);

    // back to reset values; a long full-scale frame
    settle();
    set_regs(18'd44100, 18'd2, 18'd16, 18'd4);
    repeat (4) push_frame(1 + $urandom_range(3), FR_SILENT);
    push_frame(40, FR_FULL);
    random_phase(20, 2);

    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ascd_pkg.sv
sv/audio_silence_cut_detector.sv
tb/audio_silence_cut_detector_tb.sv
